// File: rtl/core/co2_frame_check_and_rate_tracker_macros.svh
// Assertion helpers shared by the frame checker RTL.
`ifndef CO2_FRAME_CHECK_AND_RATE_TRACKER_MACROS_SVH
`define CO2_FRAME_CHECK_AND_RATE_TRACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CO2FC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CO2FC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/co2fc_pkg.sv
package co2fc_pkg;

  // Ring depth default.
  localparam int HISTORY_DEPTH_DEF = 10;

  // Rate dividend: a 16-bit ppm difference scaled by 256.
  localparam int DIV_DVD_W = 24;

  // Frame constants.
  localparam logic [7:0]  HDR_BYTE0    = 8'hFF;
  localparam logic [7:0]  HDR_BYTE1    = 8'h86;
  localparam logic [7:0]  TEMP_OFFSET  = 8'd40;
  localparam logic [15:0] PPM_RESET    = 16'd420;
  localparam logic [31:0] WARMUP_RESET = 32'd60000;

  // Score constants.
  localparam logic [15:0] PPM_BASE     = 16'd450;
  localparam logic [15:0] PPM_SPAN     = 16'd400;
  localparam logic [14:0] PART_CAP     = 15'd12800;
  localparam logic [24:0] RATE_MIN     = 25'sd51;
  localparam logic [24:0] RATE_SAT     = 25'sd512;

endpackage

// File: rtl/core/co2fc_div.sv
module co2fc_div #(
  parameter int DVD_W = co2fc_pkg::DIV_DVD_W,
  parameter int DVS_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import co2fc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   shifted;
  logic             fits;
  logic [DVS_W:0]   diff;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign fits    = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  // Step counter, quotient shift register and remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DVD_W-2:0], fits};
        rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/core/co2_frame_check_and_rate_tracker.sv
// An item that does not end a frame is taken and gives no result. The ninth item of a bad
// frame gives its result in the cycle after it is taken; the ninth item of a good frame
// gives it after ST_LOAD reads the updated ring, the divide (24 steps) on the shift-subtract
// divider that forms the rate and ST_SCORE. The input stalls while a frame end is worked
// on and while an earlier result waits at a ninth item. Reset (rst_n low, synchronous)
// clears out_valid and the parser, ring, valid and warm-up flags; ring and ppm load 420.
`include "co2_frame_check_and_rate_tracker_macros.svh"

module co2_frame_check_and_rate_tracker #(
  parameter int HISTORY_DEPTH = co2fc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_frame_start,
  input  logic [31:0]        in_uptime_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_ok,
  output logic [15:0]        out_co2_ppm,
  output logic signed [7:0]  out_temp_c,
  output logic signed [24:0] out_rate_q8,
  output logic [14:0]        out_score_q8,
  output logic               out_warmed_up,
  output logic               out_has_valid
);
  import co2fc_pkg::*;

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  // Byte positions within a response.
  localparam logic [3:0] POS_HDR0   = 4'd0;
  localparam logic [3:0] POS_HDR1   = 4'd1;
  localparam logic [3:0] POS_PPM_HI = 4'd2;
  localparam logic [3:0] POS_PPM_LO = 4'd3;
  localparam logic [3:0] POS_TEMP   = 4'd4;
  localparam logic [3:0] POS_CSUM   = 4'd8;
  localparam logic [3:0] POS_IDLE   = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_SCORE
  } state_t;

  state_t              state_r;
  logic [3:0]          pos_r;
  logic                hdr_ok_r;
  logic [7:0]          sum_r;
  logic [15:0]         frame_ppm_r;
  logic [7:0]          frame_temp_r;
  logic [15:0]         hist_r [HISTORY_DEPTH];
  logic [PW-1:0]       hist_pos_r;
  logic                hist_full_r;
  logic [15:0]         held_ppm_r;
  logic [7:0]          held_temp_r;
  logic signed [24:0]  held_rate_r;
  logic                valid_seen_r;
  logic                warm_r;
  logic [31:0]         warm_thr_r;
  logic                neg_r;
  logic                div_start_r;
  logic [CW-1:0]       count_r;
  logic [DIV_DVD_W-1:0] dvd_r;

  logic                out_valid_r;
  logic                out_ok_r;
  logic [15:0]         out_ppm_r;
  logic [7:0]          out_temp_r;
  logic [24:0]         out_rate_r;
  logic [14:0]         out_score_r;
  logic                out_warm_r;
  logic                out_has_r;

  logic                in_acc;
  logic [3:0]          pos_eff;
  logic                frame_good;
  logic [PW-1:0]       pos_inc;
  logic [PW-1:0]       oldest_idx;
  logic [16:0]         ppm_diff;
  logic [15:0]         ppm_mag;
  logic                div_done;
  logic [DIV_DVD_W-1:0] div_quo;
  logic [15:0]         ppm_over;
  logic [14:0]         ppm_part;
  logic [8:0]          rate_lo;
  logic [14:0]         rate_part;
  logic [14:0]         score;

  // Input handshake: no byte while a frame end is worked on, no checksum byte while a result waits.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && (pos_r == POS_CSUM));
  assign in_acc   = in_valid && !in_stall;
  assign pos_eff  = in_frame_start ? POS_HDR0 : pos_r;
  assign frame_good = hdr_ok_r && ((8'd0 - sum_r) == in_rx_byte);

  // Ring pointer arithmetic.
  assign pos_inc    = (hist_pos_r == PW'(HISTORY_DEPTH - 1)) ? '0 : hist_pos_r + 1'b1;
  assign oldest_idx = hist_full_r ? hist_pos_r : '0;

  // Newest minus oldest, split into sign and magnitude for the divider.
  assign ppm_diff = {1'b0, held_ppm_r} - {1'b0, hist_r[oldest_idx]};
  assign ppm_mag  = ppm_diff[16] ? 16'(-ppm_diff) : ppm_diff[15:0];

  // Score from the held values; each part saturates at 12800.
  assign ppm_over  = held_ppm_r - PPM_BASE;
  assign ppm_part  = (held_ppm_r <= PPM_BASE) ? '0 :
                     (ppm_over >= PPM_SPAN) ? PART_CAP : 15'({ppm_over[8:0], 5'd0});
  assign rate_lo   = held_rate_r[8:0];
  assign rate_part = (held_rate_r <= $signed(RATE_MIN)) ? '0 :
                     (held_rate_r >= $signed(RATE_SAT)) ? PART_CAP :
                     15'({rate_lo, 4'd0}) + 15'({rate_lo, 3'd0}) + 15'(rate_lo);
  assign score     = valid_seen_r ? (ppm_part + rate_part) : '0;

  co2fc_div #(
    .DVD_W (DIV_DVD_W),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (dvd_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer, frame parser, ring and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= POS_IDLE;
      hdr_ok_r     <= 1'b0;
      sum_r        <= '0;
      frame_ppm_r  <= '0;
      frame_temp_r <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= PPM_RESET;
      end
      hist_pos_r   <= '0;
      hist_full_r  <= 1'b0;
      held_ppm_r   <= PPM_RESET;
      held_temp_r  <= '0;
      held_rate_r  <= '0;
      valid_seen_r <= 1'b0;
      warm_r       <= 1'b0;
      warm_thr_r   <= WARMUP_RESET;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_wr_en) begin
        warm_thr_r <= cfg_wr_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (pos_eff <= POS_CSUM)) begin
            unique case (pos_eff)
              POS_HDR0: begin
                hdr_ok_r <= (in_rx_byte == HDR_BYTE0);
                sum_r    <= '0;
                pos_r    <= pos_eff + 1'b1;
              end
              POS_HDR1: begin
                hdr_ok_r <= hdr_ok_r && (in_rx_byte == HDR_BYTE1);
                sum_r    <= in_rx_byte;
                pos_r    <= pos_eff + 1'b1;
              end
              POS_CSUM: begin
                pos_r <= POS_IDLE;
                if (frame_good) begin
                  // Latch the frame and push it into the ring.
                  held_ppm_r   <= frame_ppm_r;
                  held_temp_r  <= frame_temp_r - TEMP_OFFSET;
                  valid_seen_r <= 1'b1;
                  if (in_uptime_ms > warm_thr_r) begin
                    warm_r <= 1'b1;
                  end
                  hist_r[hist_pos_r] <= frame_ppm_r;
                  hist_pos_r <= pos_inc;
                  if (pos_inc == '0) begin
                    hist_full_r <= 1'b1;
                  end
                  state_r <= ST_LOAD;
                end else begin
                  // Bad frame: report the unchanged held values at once.
                  out_valid_r <= 1'b1;
                  out_ok_r    <= 1'b0;
                  out_ppm_r   <= held_ppm_r;
                  out_temp_r  <= held_temp_r;
                  out_rate_r  <= held_rate_r;
                  out_score_r <= score;
                  out_warm_r  <= warm_r;
                  out_has_r   <= valid_seen_r;
                end
              end
              default: begin
                sum_r <= sum_r + in_rx_byte;
                if (pos_eff == POS_PPM_HI) begin
                  frame_ppm_r[15:8] <= in_rx_byte;
                end else if (pos_eff == POS_PPM_LO) begin
                  frame_ppm_r[7:0] <= in_rx_byte;
                end else if (pos_eff == POS_TEMP) begin
                  frame_temp_r <= in_rx_byte;
                end
                pos_r <= pos_eff + 1'b1;
              end
            endcase
          end
        end
        ST_LOAD: begin
          // Ring is updated: read the oldest sample and start the divide.
          neg_r       <= ppm_diff[16];
          dvd_r       <= {ppm_mag, 8'd0};
          count_r     <= hist_full_r ? CW'(HISTORY_DEPTH) : CW'(hist_pos_r);
          div_start_r <= 1'b1;
          state_r     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            held_rate_r <= neg_r ? 25'(-{1'b0, div_quo}) : {1'b0, div_quo};
            state_r     <= ST_SCORE;
          end
        end
        ST_SCORE: begin
          out_valid_r <= 1'b1;
          out_ok_r    <= 1'b1;
          out_ppm_r   <= held_ppm_r;
          out_temp_r  <= held_temp_r;
          out_rate_r  <= held_rate_r;
          out_score_r <= score;
          out_warm_r  <= warm_r;
          out_has_r   <= valid_seen_r;
          state_r     <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_frame_ok  = out_ok_r;
  assign out_co2_ppm   = out_ppm_r;
  assign out_temp_c    = out_temp_r;
  assign out_rate_q8   = out_rate_r;
  assign out_score_q8  = out_score_r;
  assign out_warmed_up = out_warm_r;
  assign out_has_valid = out_has_r;

  // The divider only finishes while the sequencer waits for it.
  `CO2FC_ASSERT_SAME(a_div_done_in_div, clk, rst_n, div_done, state_r == ST_DIV, "divider done outside ST_DIV")
  // The warm-up flag is sticky.
  `CO2FC_ASSERT_NEXT(a_warm_sticky, clk, rst_n, warm_r, warm_r, "warm-up flag cleared")
  // The ring becomes full exactly when the write pointer wraps to zero.
  `CO2FC_ASSERT_SAME(a_full_on_wrap, clk, rst_n, $rose(hist_full_r), hist_pos_r == '0, "ring full without wrap")
  // No valid frame yet means a zero score.
  `CO2FC_ASSERT_SAME(a_score_zero, clk, rst_n, out_valid_r && !out_has_r, out_score_r == '0, "score without valid frame")

endmodule
